// ===== rtl/cpd_pkg.sv =====
// Shared types and constants for the command packet decoder.
// Used by cpd_front, cpd_queue, cpd_back and command_packet_decoder.
package cpd_pkg;

	// top-byte opcodes
	localparam logic [7:0] OP_WRITE_LO = 8'h78;
	localparam logic [7:0] OP_WRITE_HI = 8'h7C;
	localparam logic [7:0] OP_PAD      = 8'h7F;

	// geometry target registers
	localparam logic [7:0] TGT_QUAD = 8'h44;
	localparam logic [7:0] TGT_ABS  = 8'h46;
	localparam logic [7:0] TGT_REL  = 8'h4E;

	localparam logic [23:0] LOW24 = 24'hFFFFFF;

	// path actions
	localparam logic [3:0] ACT_NONE        = 4'd0;
	localparam logic [3:0] ACT_MOVE_OPEN   = 4'd1;
	localparam logic [3:0] ACT_MOVE_CLOSED = 4'd2;
	localparam logic [3:0] ACT_LINE        = 4'd3;
	localparam logic [3:0] ACT_QUAD        = 4'd5;

	// header loop field
	localparam logic [3:0] LOOP_PAIR = 4'd2;
	localparam logic [3:0] LOOP_QUAD = 4'd4;

	// header write format (top byte minus OP_WRITE_LO)
	localparam logic [2:0] FMT_FLOAT = 3'd3;
	localparam logic [2:0] FMT_WORD  = 3'd4;

	// geometry lane formats
	localparam logic [1:0] GF_S8    = 2'd0;
	localparam logic [1:0] GF_S16   = 2'd1;
	localparam logic [1:0] GF_FLOAT = 2'd3;

	localparam int M_DATA_W = 88;

	typedef enum logic [1:0] {
		MODE_HDR  = 2'd0,
		MODE_REG  = 2'd1,
		MODE_GEOM = 2'd2,
		MODE_SKIP = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_REG  = 2'd0,
		KIND_GEOM = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE   = 3'd0,
		ERR_FORMAT = 3'd1,
		ERR_ACTION = 3'd2,
		ERR_SHAPE  = 3'd3,
		ERR_TARGET = 3'd4,
		ERR_RAW    = 3'd5
	} err_t;

	// one decoded word: expands to count results in the back end
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  addr;
		logic [31:0] word;
		logic [3:0]  action;
		logic [1:0]  fmt;
		logic        rel;
		logic        quad;
		logic [1:0]  pos;
		logic [2:0]  count;
		err_t        err;
	} job_t;

endpackage

// ===== rtl/command_packet_decoder.sv =====
// Command packet decoder top level: front end, job queue, back end.
// Depends on cpd_pkg, cpd_front, cpd_queue, cpd_back.
//
// channel  | dir | tdata                     | tuser             | tlast
// s_axis   | in  | command_word[31:0]        | first_in_packet   | -
// m_axis   | out | see port comment          | result_kind[1:0]  | last
//
// One command word is accepted per cycle while the job queue has room.
// Results leave one per cycle unless the output stalls; an 8-bit geometry word
// yields up to four, a 16-bit word up to two, so output bandwidth sets the rate
// for packed geometry. A word goes through the queue and the output register.
// Reset is asynchronous: parse state returns to header mode, queue and output empty.
// Output stalls back up through the queue; s_axis_tready drops only when it is full.
module command_packet_decoder
	import cpd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [31:0]         s_axis_tdata,   // command_word[31:0]
	input  logic                s_axis_tuser,   // first_in_packet
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// reg_addr[7:0], reg_data[39:8], geom_action[43:40], geom_value[75:44],
	// geom_is_float[76], geom_relative[77], coord_index[79:78], error_code[82:80]
	output logic [M_DATA_W-1:0] m_axis_tdata,
	output logic [1:0]          m_axis_tuser,   // result_kind[1:0]
	output logic                m_axis_tlast
);

	logic push, q_full, pop, head_valid;
	job_t push_job, head;

	cpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_word  (s_axis_tdata),
		.in_first (s_axis_tuser),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	cpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	cpd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== rtl/cpd_front.sv =====
// Front end: accepts command words, tracks packet parse state, emits jobs.
// Depends on cpd_pkg.
module cpd_front
	import cpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] in_word,
	input  logic        in_first,
	input  logic        q_full,
	output logic        push,
	output job_t        push_job
);

	mode_t       mode_q, mode_n;
	logic [7:0]  items_q, items_n;
	logic [7:0]  target_q, target_n;
	logic [1:0]  fmt_q, fmt_n;
	logic [3:0]  action_q, action_n;
	logic [1:0]  pos_q, pos_n;
	logic        rel_q, rel_n;

	logic        accept;
	mode_t       mode_eff;
	logic [7:0]  hdr_top, hdr_a, hdr_cnt;
	logic [3:0]  hdr_loop, hdr_act;
	logic [2:0]  hdr_fmt;
	logic        hdr_pad, hdr_direct, hdr_quad;
	err_t        hdr_err;
	logic        quad_q;
	logic [2:0]  lanes, n_lanes;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign mode_eff = in_first ? MODE_HDR : mode_q;

	assign hdr_top    = in_word[31:24];
	assign hdr_a      = in_word[7:0];
	assign hdr_cnt    = in_word[15:8];
	assign hdr_loop   = in_word[19:16];
	assign hdr_act    = in_word[23:20];
	assign hdr_fmt    = 3'(hdr_top - OP_WRITE_LO);
	assign hdr_pad    = (hdr_top == OP_PAD);
	assign hdr_direct = (hdr_top < OP_WRITE_LO) || (hdr_top > OP_WRITE_HI);
	assign hdr_quad   = (hdr_act == ACT_QUAD);

	assign quad_q  = (action_q == ACT_QUAD);
	assign lanes   = (fmt_q == GF_S8) ? 3'd4 : (fmt_q == GF_S16) ? 3'd2 : 3'd1;
	assign n_lanes = (items_q < {5'd0, lanes}) ? items_q[2:0] : lanes;

	// header checks: action, loop/count shape, target, format
	always_comb begin
		hdr_err = ERR_NONE;
		if (hdr_act == ACT_NONE) begin
			if (hdr_fmt != FMT_FLOAT && hdr_fmt != FMT_WORD)
				hdr_err = ERR_FORMAT;
		end else if (hdr_act != ACT_MOVE_OPEN && hdr_act != ACT_MOVE_CLOSED &&
				hdr_act != ACT_LINE && !hdr_quad) begin
			hdr_err = ERR_ACTION;
		end else if (hdr_quad) begin
			if (hdr_loop != LOOP_QUAD || hdr_cnt == 8'd0 || hdr_cnt[1:0] != 2'd0)
				hdr_err = ERR_SHAPE;
			else if (hdr_a != TGT_QUAD)
				hdr_err = ERR_TARGET;
			else if (hdr_fmt == FMT_WORD)
				hdr_err = ERR_RAW;
		end else begin
			if (hdr_loop != LOOP_PAIR || hdr_cnt == 8'd0 || hdr_cnt[0])
				hdr_err = ERR_SHAPE;
			else if (hdr_a != TGT_ABS && !(hdr_a == TGT_REL && hdr_act == ACT_LINE))
				hdr_err = ERR_TARGET;
			else if (hdr_fmt == FMT_WORD)
				hdr_err = ERR_RAW;
		end
	end

	// next parse state
	always_comb begin
		mode_n   = mode_q;
		items_n  = items_q;
		target_n = target_q;
		fmt_n    = fmt_q;
		action_n = action_q;
		pos_n    = pos_q;
		rel_n    = rel_q;
		if (accept) begin
			if (in_first) begin
				mode_n  = MODE_HDR;
				items_n = 8'd0;
			end
			case (mode_eff)
				MODE_REG: begin
					target_n = target_q + 8'd1;
					items_n  = items_q - 8'd1;
					if (items_q == 8'd1)
						mode_n = MODE_HDR;
				end
				MODE_GEOM: begin
					items_n = items_q - {5'd0, n_lanes};
					pos_n   = quad_q ? (pos_q + n_lanes[1:0]) : {1'b0, pos_q[0] ^ n_lanes[0]};
					if (items_q == {5'd0, n_lanes})
						mode_n = MODE_HDR;
				end
				MODE_SKIP: begin
				end
				default: begin
					if (!hdr_pad && !hdr_direct) begin
						if (hdr_err != ERR_NONE) begin
							mode_n  = MODE_SKIP;
							items_n = 8'd0;
						end else if (hdr_act == ACT_NONE) begin
							if (hdr_cnt != 8'd0) begin
								mode_n   = MODE_REG;
								items_n  = hdr_cnt;
								target_n = hdr_a;
							end
						end else begin
							mode_n   = MODE_GEOM;
							items_n  = hdr_cnt;
							target_n = hdr_a;
							fmt_n    = hdr_fmt[1:0];
							action_n = hdr_act;
							pos_n    = 2'd0;
							rel_n    = (hdr_a == TGT_REL);
						end
					end
				end
			endcase
		end
	end

	// job for the queue
	always_comb begin
		push     = 1'b0;
		push_job = '0;
		if (accept) begin
			case (mode_eff)
				MODE_REG: begin
					push           = 1'b1;
					push_job.kind  = KIND_REG;
					push_job.addr  = target_q;
					push_job.word  = in_word;
					push_job.count = 3'd1;
				end
				MODE_GEOM: begin
					push            = (n_lanes != 3'd0);
					push_job.kind   = KIND_GEOM;
					push_job.word   = in_word;
					push_job.action = action_q;
					push_job.fmt    = fmt_q;
					push_job.rel    = rel_q;
					push_job.quad   = quad_q;
					push_job.pos    = pos_q;
					push_job.count  = n_lanes;
				end
				MODE_SKIP: begin
				end
				default: begin
					if (!hdr_pad && hdr_direct) begin
						push           = 1'b1;
						push_job.kind  = KIND_REG;
						push_job.addr  = hdr_top;
						push_job.word  = {8'd0, in_word[23:0] & LOW24};
						push_job.count = 3'd1;
					end else if (!hdr_pad && hdr_err != ERR_NONE) begin
						push           = 1'b1;
						push_job.kind  = KIND_ERR;
						push_job.err   = hdr_err;
						push_job.count = 3'd1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_HDR;
			items_q  <= 8'd0;
			target_q <= 8'd0;
			fmt_q    <= 2'd0;
			action_q <= 4'd0;
			pos_q    <= 2'd0;
			rel_q    <= 1'b0;
		end else begin
			mode_q   <= mode_n;
			items_q  <= items_n;
			target_q <= target_n;
			fmt_q    <= fmt_n;
			action_q <= action_n;
			pos_q    <= pos_n;
			rel_q    <= rel_n;
		end
	end

	a_err_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_job.kind == KIND_ERR) |=> (mode_q == MODE_SKIP))
		else $error("error result not followed by skip mode");

	a_reg_items: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_REG || mode_q == MODE_GEOM) |-> (items_q != 8'd0))
		else $error("data mode with no items left");

endmodule

// ===== rtl/cpd_queue.sv =====
// Small job queue between front and back end (register file + pointers).
// Depends on cpd_pkg.
module cpd_queue
	import cpd_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t head,
	output logic head_valid
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

// ===== rtl/cpd_back.sv =====
// Back end: expands queued jobs into results, one per cycle unless the output stalls, into the output register.
// Depends on cpd_pkg.
module cpd_back
	import cpd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  job_t                head,
	input  logic                head_valid,
	output logic                pop,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [M_DATA_W-1:0] m_axis_tdata,
	output logic [1:0]          m_axis_tuser,
	output logic                m_axis_tlast
);

	logic [1:0]          lane_q;
	logic                last_lane, advance;
	logic                m_valid_q;
	logic [M_DATA_W-1:0] m_data_q;
	logic [1:0]          m_user_q;
	logic                m_last_q;

	logic [7:0]          r_addr;
	logic [31:0]         r_data, r_value;
	logic [3:0]          r_action;
	logic                r_isf, r_rel;
	logic [1:0]          r_ci;
	logic [2:0]          r_err;
	logic [7:0]          lane_byte;
	logic [15:0]         lane_half;
	logic [M_DATA_W-1:0] r_tdata;

	assign last_lane = (({1'b0, lane_q} + 3'd1) == head.count);
	assign advance   = !m_valid_q || m_axis_tready;
	assign pop       = advance && head_valid && last_lane;

	assign lane_byte = head.word[{lane_q, 3'b000} +: 8];
	assign lane_half = lane_q[0] ? head.word[31:16] : head.word[15:0];

	always_comb begin
		r_addr   = 8'd0;
		r_data   = 32'd0;
		r_value  = 32'd0;
		r_action = 4'd0;
		r_isf    = 1'b0;
		r_rel    = 1'b0;
		r_ci     = 2'd0;
		r_err    = ERR_NONE;
		case (head.kind)
			KIND_REG: begin
				r_addr = head.addr;
				r_data = head.word;
			end
			KIND_GEOM: begin
				r_action = head.action;
				r_isf    = (head.fmt == GF_FLOAT);
				r_rel    = head.rel;
				r_ci     = head.quad ? (head.pos + lane_q) : {1'b0, head.pos[0] ^ lane_q[0]};
				case (head.fmt)
					GF_S8:   r_value = {{24{lane_byte[7]}}, lane_byte};
					GF_S16:  r_value = {{16{lane_half[15]}}, lane_half};
					default: r_value = head.word;
				endcase
			end
			KIND_ERR: r_err = head.err;
			default: begin
			end
		endcase
	end

	assign r_tdata = {5'd0, r_err, r_ci, r_rel, r_isf, r_value, r_action, r_data, r_addr};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			lane_q    <= 2'd0;
		end else if (advance) begin
			m_valid_q <= head_valid;
			if (head_valid)
				lane_q <= last_lane ? 2'd0 : lane_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && head_valid) begin
			m_data_q <= r_tdata;
			m_user_q <= head.kind;
			m_last_q <= last_lane;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

	a_lane_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> ({1'b0, lane_q} < head.count))
		else $error("lane index past job count");

	a_mid_job_head: assert property (@(posedge clk) disable iff (!arst_n)
		(lane_q != 2'd0) |-> head_valid)
		else $error("job left the queue mid expansion");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && head.kind != KIND_GEOM) |-> (head.count == 3'd1))
		else $error("non-geometry job with several results");

endmodule
